>>> hw/rtl/lprd_pkg.sv
// Shared types and codes for the length-prefixed request deframer.
package lprd_pkg;

  localparam int unsigned HDR_CNT_W = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_TAIL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_COUNT_SHORT = 3'd1,
    ST_LEN_SHORT   = 3'd2,
    ST_BODY_SHORT  = 3'd3,
    ST_TRAILING    = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              end_of_request;
  } item_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [WORD_W-1:0] string_index;
    logic              string_end;
    logic              request_done;
    status_t           status;
  } result_t;

endpackage

>>> hw/rtl/lprd_in_reg.sv
// Input register stage: capture one request byte transaction, hold it until parsed.
module lprd_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  lprd_pkg::item_t  item_in,
  input  logic             advance,
  output logic             item_valid,
  output lprd_pkg::item_t  item_out
);

  logic            valid_r;
  logic            valid_nxt;
  lprd_pkg::item_t item_r;

  // accept when empty or when the held item moves on this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_in;
    end
  end

  assign item_valid = valid_r;
  assign item_out   = item_r;

endmodule

>>> hw/rtl/lprd_parse.sv
// Deframing state and per-byte decode: header gathering, string counting, status.
module lprd_parse #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  lprd_pkg::item_t   item,
  output lprd_pkg::result_t result
);

  localparam logic [lprd_pkg::HDR_CNT_W-1:0] HdrBytesC =
    lprd_pkg::HDR_CNT_W'(HEADER_BYTES);

  lprd_pkg::phase_t                 phase_r, phase_nxt, phase_post;
  logic [lprd_pkg::HDR_CNT_W-1:0]   hcnt_r, hcnt_nxt, hcnt_post;
  logic [lprd_pkg::WORD_W-1:0]      hacc_r, hacc_nxt, hacc_post;
  logic [lprd_pkg::WORD_W-1:0]      expected_r, expected_nxt, expected_post;
  logic [lprd_pkg::WORD_W-1:0]      sdone_r, sdone_nxt, sdone_post;
  logic [lprd_pkg::WORD_W-1:0]      remain_r, remain_nxt, remain_post;
  logic                             trail_r, trail_nxt, trail_post;

  logic [lprd_pkg::HDR_CNT_W-1:0]   hcnt_inc;
  logic                             hdr_done;
  logic [lprd_pkg::WORD_W-1:0]      hdr_val;
  logic [lprd_pkg::WORD_W-1:0]      sdone_inc;
  logic                             last_string;
  logic [lprd_pkg::WORD_W-1:0]      remain_dec;

  assign hcnt_inc    = hcnt_r + lprd_pkg::HDR_CNT_W'(1);
  assign hdr_done    = (hcnt_inc >= HdrBytesC);
  assign hdr_val     = hacc_r |
                       (lprd_pkg::WORD_W'(item.data_byte) << {hcnt_r[1:0], 3'b000});
  assign sdone_inc   = sdone_r + lprd_pkg::WORD_W'(1);
  assign last_string = (sdone_inc == expected_r);
  assign remain_dec  = remain_r - lprd_pkg::WORD_W'(1);

  // next state: byte first, then end of request returns everything to reset
  always_comb begin
    phase_post    = phase_r;
    hcnt_post     = hcnt_r;
    hacc_post     = hacc_r;
    expected_post = expected_r;
    sdone_post    = sdone_r;
    remain_post   = remain_r;
    trail_post    = trail_r;
    if (item.byte_present) begin
      case (phase_r)
        lprd_pkg::PH_COUNT: begin
          hacc_post = hdr_val;
          hcnt_post = hcnt_inc;
          if (hdr_done) begin
            expected_post = hdr_val;
            sdone_post    = '0;
            hacc_post     = '0;
            hcnt_post     = '0;
            phase_post    = (hdr_val == '0) ? lprd_pkg::PH_TAIL : lprd_pkg::PH_LEN;
          end
        end
        lprd_pkg::PH_LEN: begin
          hacc_post = hdr_val;
          hcnt_post = hcnt_inc;
          if (hdr_done) begin
            remain_post = hdr_val;
            hacc_post   = '0;
            hcnt_post   = '0;
            if (hdr_val == '0) begin
              sdone_post = sdone_inc;
              phase_post = last_string ? lprd_pkg::PH_TAIL : lprd_pkg::PH_LEN;
            end else begin
              phase_post = lprd_pkg::PH_BODY;
            end
          end
        end
        lprd_pkg::PH_BODY: begin
          remain_post = remain_dec;
          if (remain_dec == '0) begin
            sdone_post = sdone_inc;
            phase_post = last_string ? lprd_pkg::PH_TAIL : lprd_pkg::PH_LEN;
          end
        end
        default: begin
          trail_post = 1'b1;
        end
      endcase
    end

    phase_nxt    = phase_post;
    hcnt_nxt     = hcnt_post;
    hacc_nxt     = hacc_post;
    expected_nxt = expected_post;
    sdone_nxt    = sdone_post;
    remain_nxt   = remain_post;
    trail_nxt    = trail_post;
    if (item.end_of_request) begin
      phase_nxt    = lprd_pkg::PH_COUNT;
      hcnt_nxt     = '0;
      hacc_nxt     = '0;
      expected_nxt = '0;
      sdone_nxt    = '0;
      remain_nxt   = '0;
      trail_nxt    = 1'b0;
    end
  end

  // result fields for the byte being parsed
  always_comb begin
    result = '0;
    if (item.byte_present) begin
      case (phase_r)
        lprd_pkg::PH_LEN: begin
          result.string_index = sdone_r;
          result.string_end   = hdr_done && (hdr_val == '0);
        end
        lprd_pkg::PH_BODY: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = item.data_byte;
          result.string_index  = sdone_r;
          result.string_end    = (remain_dec == '0);
        end
        default: begin
          result.string_index = '0;
        end
      endcase
    end
    if (item.end_of_request) begin
      result.request_done = 1'b1;
      case (phase_post)
        lprd_pkg::PH_COUNT: result.status = lprd_pkg::ST_COUNT_SHORT;
        lprd_pkg::PH_LEN:   result.status = lprd_pkg::ST_LEN_SHORT;
        lprd_pkg::PH_BODY:  result.status = lprd_pkg::ST_BODY_SHORT;
        default: begin
          result.status = trail_post ? lprd_pkg::ST_TRAILING : lprd_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lprd_pkg::PH_COUNT;
      hcnt_r     <= '0;
      hacc_r     <= '0;
      expected_r <= '0;
      sdone_r    <= '0;
      remain_r   <= '0;
      trail_r    <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      hacc_r     <= hacc_nxt;
      expected_r <= expected_nxt;
      sdone_r    <= sdone_nxt;
      remain_r   <= remain_nxt;
      trail_r    <= trail_nxt;
    end
  end

endmodule

>>> hw/rtl/lprd_out_reg.sv
// Result register: hold one decoded result until the downstream takes it.
module lprd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  lprd_pkg::result_t  result_in,
  input  logic               out_tready,
  output logic               out_tvalid,
  output lprd_pkg::result_t  result_out
);

  logic              valid_r;
  logic              valid_nxt;
  lprd_pkg::result_t result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign out_tvalid = valid_r;
  assign result_out = result_r;

endmodule

>>> hw/rtl/length_prefixed_request_deframer_core.sv
// Top level of the length-prefixed request deframer.
//
// Takes one request byte per transaction and returns exactly one result transaction
// for each. A request opens with a little-endian string-count header of HEADER_BYTES
// bytes (1 to 4); every string follows as a little-endian length header of
// HEADER_BYTES bytes and then that many content bytes. Content bytes come out with
// payload_valid set and tagged with their zero-based string index; string_end marks
// the last content byte of a string, or the last length-header byte of an empty one.
// in_tlast ends the request after the byte in the same transaction (if in_tuser says
// a byte is present); the matching result carries out_tlast and a status: ok, count
// short, length short, content short, or trailing data (bytes after the last string
// are dropped). The parser then returns to its reset state. Downstream drops the
// streamed strings when the status is not ok.
// Throughput is one transaction per clock while out_tready is high: the input
// register, the per-byte decode (32-bit increment, decrement and compares) and the
// result register sit in one pass, and the input register can take one more byte
// while a result waits. Each accepted byte is held first in the input register,
// then its result in the result register; a stalled out_tready holds them there.
module length_prefixed_request_deframer_core #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_request
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] payload_byte, [39:8] string_index,
                                  // [42:40] status, [47:43] zero
  output logic [1:0]  out_tuser,  // [0] payload_valid, [1] string_end
  output logic        out_tlast   // request_done
);

  lprd_pkg::item_t   item_in;
  lprd_pkg::item_t   item_held;
  logic              item_valid;
  logic              out_free;
  logic              advance;
  lprd_pkg::result_t result_new;
  lprd_pkg::result_t result_held;

  assign item_in.data_byte      = in_tdata;
  assign item_in.byte_present   = in_tuser;
  assign item_in.end_of_request = in_tlast;

  // advance the held byte whenever the result register is empty or draining
  assign out_free = !out_tvalid || out_tready;
  assign advance  = item_valid && out_free;

  lprd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item_out   (item_held)
  );

  lprd_parse #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_held),
    .result  (result_new)
  );

  lprd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result_in  (result_new),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .result_out (result_held)
  );

  // pack the result transaction, highest field first
  assign out_tdata = {5'b0, result_held.status, result_held.string_index,
                      result_held.payload_byte};
  assign out_tuser = {result_held.string_end, result_held.payload_valid};
  assign out_tlast = result_held.request_done;

`ifndef SYNTH
  // status is only reported on the end-of-request result
  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[42:40] == lprd_pkg::ST_OK)
    else $error("nonzero status without request_done");

  // non-payload results carry a zero byte
  a_byte_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("payload byte set without payload_valid");

  // a held byte that cannot advance stays held
  a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !out_free |=> item_valid)
    else $error("input item lost during output stall");

  // every advanced byte lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("advanced item produced no result");
`endif

endmodule
